[sv/reload_down_timer_regs_core_assert.svh]
// assertion macros for the reload down-timer register block
// used by the core and the timer datapath, no other dependencies
`ifndef RELOAD_DOWN_TIMER_REGS_CORE_ASSERT_SVH
`define RELOAD_DOWN_TIMER_REGS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RDT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RDT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RDT_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define RDT_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

[sv/rdt_pkg.sv]
// shared types and constants for the reload down-timer register block
// no dependencies
package rdt_pkg;

   // fixed field widths of the request and response channels
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 2;
   localparam int DATA_W = 24;
   localparam int WIDE_W = 32;

   // defaults for the top level parameters
   localparam int COUNT_WIDTH_DEF = 24;
   localparam int REF_DIVIDE_DEF  = 8;

   // control register layout
   localparam int CTL_W        = 4;
   localparam int CTL_EN_BIT   = 0;
   localparam int CTL_INT_BIT  = 1;
   localparam int CTL_CLK_BIT  = 2;
   localparam int CTL_ONE_BIT  = 3;
   localparam int FLAG_BIT     = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      REG_CTRL    = 2'd0,
      REG_RELOAD  = 2'd1,
      REG_CURRENT = 2'd2,
      REG_ELAPSED = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
   } rdt_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              interrupt_pulse;
   } rdt_rsp_type;

endpackage

[sv/rdt_req_if.sv]
// request channel of the reload down-timer register block
// depends on rdt_pkg for field widths
interface rdt_req_if;
   logic                        valid;
   logic                        ready;
   logic [rdt_pkg::CMD_W-1:0]   cmd;
   logic [rdt_pkg::IDX_W-1:0]   reg_index;
   logic [rdt_pkg::DATA_W-1:0]  write_data;

   modport source (output valid, output cmd, output reg_index, output write_data,
                   input ready);
   modport sink (input valid, input cmd, input reg_index, input write_data,
                 output ready);
endinterface

[sv/rdt_rsp_if.sv]
// response channel of the reload down-timer register block
// depends on rdt_pkg for field widths
interface rdt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rdt_pkg::DATA_W-1:0]  read_data;
   logic                        interrupt_pulse;

   modport source (output valid, output read_data, output interrupt_pulse,
                   input ready);
   modport sink (input valid, input read_data, input interrupt_pulse,
                 output ready);
endinterface

[sv/reload_down_timer_regs_core.sv]
// Reload down-timer behind four registers (control, reload, current value,
// elapsed). Every request is a core clock tick, a register read or a register
// write, and every request returns exactly one response, registered in the
// output or skid register and held while the response side holds off,
// carrying the read data and the interrupt pulse. One request is
// accepted per clock: the timer state updates in the accepting cycle and the
// response lands in an output register backed by a one-entry skid register,
// so the request side only stalls when both of those hold undelivered
// responses. COUNT_WIDTH sets the counter and reload width, REF_DIVIDE the
// prescale ratio of the divided clock source.
// depends on rdt_pkg, rdt_req_if, rdt_rsp_if, rdt_timer and the assertion header
`include "reload_down_timer_regs_core_assert.svh"

module reload_down_timer_regs_core #(
   parameter int COUNT_WIDTH = rdt_pkg::COUNT_WIDTH_DEF,
   parameter int REF_DIVIDE  = rdt_pkg::REF_DIVIDE_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rdt_req_if.sink   req_port,
   rdt_rsp_if.source rsp_port
);
   import rdt_pkg::*;

   rdt_req_type req;
   rdt_rsp_type result;
   logic        accept;
   logic        pop;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   rdt_rsp_type out_ff, out_in;
   rdt_rsp_type skid_ff, skid_in;

   // request handshake
   assign req_port.ready = !skid_valid_ff;
   assign accept         = req_port.valid && req_port.ready;
   assign pop            = out_valid_ff && rsp_port.ready;

   assign req.cmd        = req_port.cmd;
   assign req.reg_index  = req_port.reg_index;
   assign req.write_data = req_port.write_data;

   rdt_timer #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .REF_DIVIDE  (REF_DIVIDE)
   ) u_timer (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req),
      .rsp   (result)
   );

   // output register and skid slot
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_port.valid           = out_valid_ff;
   assign rsp_port.read_data       = out_ff.read_data;
   assign rsp_port.interrupt_pulse = out_ff.interrupt_pulse;

   // checks
   `RDT_ASSERT_NXT(a_accept_gives_rsp, clock, reset, accept, out_valid_ff,
                   "accepted request left no response")
   `RDT_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
                   "skid slot full with output empty")
   `RDT_ASSERT_NXT(a_skid_drains, clock, reset, skid_valid_ff && pop,
                   !skid_valid_ff && out_valid_ff, "skid slot did not drain")

endmodule

[sv/rdt_timer.sv]
// timer state and register file: counter, reload, control, flag, prescaler
// depends on rdt_pkg and the assertion macro header
`include "reload_down_timer_regs_core_assert.svh"

module rdt_timer #(
   parameter int COUNT_WIDTH = rdt_pkg::COUNT_WIDTH_DEF,
   parameter int REF_DIVIDE  = rdt_pkg::REF_DIVIDE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  rdt_pkg::rdt_req_type req,
   output rdt_pkg::rdt_rsp_type rsp
);
   import rdt_pkg::*;

   localparam int DIV_W = (REF_DIVIDE > 2) ? $clog2(REF_DIVIDE) : 1;
   localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(REF_DIVIDE - 1);

   logic [CTL_W-1:0]       ctl_ff, ctl_in;
   logic                   flag_ff, flag_in;
   logic [COUNT_WIDTH-1:0] reload_ff, reload_in;
   logic [COUNT_WIDTH-1:0] cur_ff, cur_in;
   logic [DIV_W-1:0]       div_ff, div_in;

   logic [WIDE_W-1:0]      wdata_wide;
   logic [WIDE_W-1:0]      reload_wide;
   logic [WIDE_W-1:0]      cur_wide;
   logic [WIDE_W-1:0]      elapsed_wide;
   logic [COUNT_WIDTH-1:0] elapsed;
   logic [COUNT_WIDTH-1:0] cur_dec;
   logic                   cur_zero;
   logic                   cur_one;
   logic                   advance;

   // width adaptation between the 24-bit bus and the counter width
   assign wdata_wide   = WIDE_W'(req.write_data);
   assign reload_wide  = WIDE_W'(reload_ff);
   assign cur_wide     = WIDE_W'(cur_ff);
   assign elapsed      = reload_ff - cur_ff;
   assign elapsed_wide = WIDE_W'(elapsed);
   assign cur_dec      = cur_ff - COUNT_WIDTH'(1);
   assign cur_zero     = (cur_ff == '0);
   assign cur_one      = (cur_ff == COUNT_WIDTH'(1));

   // decide whether this tick reaches the counter, advance the prescaler when divided
   always_comb begin
      advance = 1'b0;
      div_in  = div_ff;
      if (step && req.cmd == CMD_TICK && ctl_ff[CTL_EN_BIT]) begin
         if (ctl_ff[CTL_CLK_BIT]) begin
            advance = 1'b1;
         end else if (div_ff == DIV_LAST) begin
            div_in  = '0;
            advance = 1'b1;
         end else begin
            div_in = div_ff + DIV_W'(1);
         end
      end
   end

   // register reads, writes and counter update
   always_comb begin
      ctl_in              = ctl_ff;
      flag_in             = flag_ff;
      reload_in           = reload_ff;
      cur_in              = cur_ff;
      rsp.read_data       = '0;
      rsp.interrupt_pulse = 1'b0;
      if (step) begin
         case (req.cmd)
            CMD_TICK: begin
               if (advance) begin
                  if (cur_zero) begin
                     cur_in = reload_ff;
                  end else begin
                     cur_in = cur_dec;
                     if (cur_one) begin
                        flag_in             = 1'b1;
                        rsp.interrupt_pulse = ctl_ff[CTL_INT_BIT];
                        // one-shot expiry stops and clears the timer
                        if (ctl_ff[CTL_ONE_BIT]) begin
                           ctl_in[CTL_EN_BIT]  = 1'b0;
                           ctl_in[CTL_INT_BIT] = 1'b0;
                           reload_in           = '0;
                           cur_in              = '0;
                        end
                     end
                  end
               end
            end
            CMD_READ: begin
               case (req.reg_index)
                  REG_CTRL: begin
                     rsp.read_data           = DATA_W'(ctl_ff);
                     rsp.read_data[FLAG_BIT] = flag_ff;
                     flag_in                 = 1'b0;
                  end
                  REG_RELOAD:  rsp.read_data = reload_wide[DATA_W-1:0];
                  REG_CURRENT: rsp.read_data = cur_wide[DATA_W-1:0];
                  REG_ELAPSED: rsp.read_data = elapsed_wide[DATA_W-1:0];
                  default:     rsp.read_data = '0;
               endcase
            end
            CMD_WRITE: begin
               case (req.reg_index)
                  REG_CTRL:   ctl_in    = req.write_data[CTL_W-1:0];
                  REG_RELOAD: reload_in = wdata_wide[COUNT_WIDTH-1:0];
                  REG_CURRENT: begin
                     cur_in  = '0;
                     flag_in = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         flag_ff   <= 1'b0;
         reload_ff <= '0;
         cur_ff    <= '0;
         div_ff    <= '0;
      end else begin
         ctl_ff    <= ctl_in;
         flag_ff   <= flag_in;
         reload_ff <= reload_in;
         cur_ff    <= cur_in;
         div_ff    <= div_in;
      end
   end

   // checks
   `RDT_ASSERT_IMP(a_div_range, clock, reset, 1'b1, div_ff <= DIV_LAST, "prescaler out of range")
   `RDT_ASSERT_NXT(a_one_shot_stop, clock, reset, advance && cur_one && ctl_ff[CTL_ONE_BIT], !ctl_ff[CTL_EN_BIT] && cur_ff == '0 && reload_ff == '0, "one-shot expiry did not stop timer")
   `RDT_ASSERT_IMP(a_flag_source, clock, reset, $rose(flag_ff), $past(advance) && $past(cur_one), "count flag set without expiry")
   `RDT_ASSERT_IMP(a_irq_needs_int, clock, reset, rsp.interrupt_pulse, ctl_ff[CTL_INT_BIT] && advance, "interrupt without enable or tick")

endmodule
